// ----- sv/caf_pkg.sv -----
// Package: operation codes and request/response payload types of the ALU and flag unit.
`default_nettype none
package caf_pkg;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_ADC   = 4'd1,
    KIND_SUB   = 4'd2,
    KIND_SBC   = 4'd3,
    KIND_AND   = 4'd4,
    KIND_XOR   = 4'd5,
    KIND_OR    = 4'd6,
    KIND_CP    = 4'd7,
    KIND_INC   = 4'd8,
    KIND_DEC   = 4'd9,
    KIND_DAA   = 4'd10,
    KIND_CPL   = 4'd11,
    KIND_SCF   = 4'd12,
    KIND_CCF   = 4'd13,
    KIND_ADD16 = 4'd14,
    KIND_ADDSP = 4'd15
  } caf_kind_e;

  // DAA correction constants
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [3:0] DaaLoLimit = 4'h9;

  typedef struct packed {
    caf_kind_e   kind;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [15:0] wide_base;
    logic [15:0] wide_addend;
    logic        zero_in;
    logic        subtract_in;
    logic        half_in;
    logic        carry_in;
  } caf_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_out;
    logic        subtract_out;
    logic        half_out;
    logic        carry_out;
  } caf_rsp_t;

endpackage
`default_nettype wire

// ----- sv/caf_stream_if.sv -----
// Interface: valid/ready stream channel with a typed payload.
`default_nettype none
interface caf_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/caf_alu.sv -----
// Module: combinational ALU datapath and flag logic for one request.
`default_nettype none
module caf_alu (
  input  caf_pkg::caf_req_t req_i,
  output caf_pkg::caf_rsp_t rsp_o
);

  logic [7:0]  a;
  logic [7:0]  v;
  logic        cin;
  logic [8:0]  add9;
  logic [4:0]  add_nib;
  logic [8:0]  sub9;
  logic [4:0]  sub_nib;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  daa8;
  logic        daa_c;
  logic [16:0] add17;
  logic [12:0] add_lo12;
  logic [15:0] ofs16;
  logic [8:0]  ofs_byte;
  logic [4:0]  ofs_nib;
  logic [7:0]  byte_r;

  assign a = req_i.acc;
  assign v = req_i.operand;

  // carry-in only for ADC/SBC
  always_comb begin
    case (req_i.kind) inside
      caf_pkg::KIND_ADC, caf_pkg::KIND_SBC: cin = req_i.carry_in;
      default:                              cin = 1'b0;
    endcase
  end

  assign add9    = {1'b0, a} + {1'b0, v} + {8'd0, cin};
  assign add_nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
  assign sub9    = {1'b0, a} - {1'b0, v} - {8'd0, cin};
  assign sub_nib = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
  assign inc8    = v + 8'd1;
  assign dec8    = v - 8'd1;

  always_comb begin
    daa8  = a;
    daa_c = req_i.carry_in;
    if (req_i.subtract_in) begin
      if (req_i.carry_in) daa8 = daa8 - caf_pkg::DaaHiAdj;
      if (req_i.half_in)  daa8 = daa8 - caf_pkg::DaaLoAdj;
    end else begin
      if (req_i.carry_in || (a > caf_pkg::DaaHiLimit)) begin
        daa8  = daa8 + caf_pkg::DaaHiAdj;
        daa_c = 1'b1;
      end
      if (req_i.half_in || (a[3:0] > caf_pkg::DaaLoLimit)) daa8 = daa8 + caf_pkg::DaaLoAdj;
    end
  end

  assign add17    = {1'b0, req_i.wide_base} + {1'b0, req_i.wide_addend};
  assign add_lo12 = {1'b0, req_i.wide_base[11:0]} + {1'b0, req_i.wide_addend[11:0]};
  assign ofs16    = req_i.wide_base + {{8{v[7]}}, v};
  assign ofs_byte = {1'b0, req_i.wide_base[7:0]} + {1'b0, v};
  assign ofs_nib  = {1'b0, req_i.wide_base[3:0]} + {1'b0, v[3:0]};

  always_comb begin
    byte_r             = a;
    rsp_o.result       = 16'd0;
    rsp_o.zero_out     = req_i.zero_in;
    rsp_o.subtract_out = req_i.subtract_in;
    rsp_o.half_out     = req_i.half_in;
    rsp_o.carry_out    = req_i.carry_in;
    unique case (req_i.kind) inside
      caf_pkg::KIND_ADD, caf_pkg::KIND_ADC: begin
        byte_r             = add9[7:0];
        rsp_o.subtract_out = 1'b0;
        rsp_o.half_out     = add_nib[4];
        rsp_o.carry_out    = add9[8];
      end
      caf_pkg::KIND_SUB, caf_pkg::KIND_SBC, caf_pkg::KIND_CP: begin
        // CP keeps the accumulator; flags come from the difference
        byte_r             = (req_i.kind == caf_pkg::KIND_CP) ? a : sub9[7:0];
        rsp_o.subtract_out = 1'b1;
        rsp_o.half_out     = sub_nib[4];
        rsp_o.carry_out    = sub9[8];
      end
      caf_pkg::KIND_AND: begin
        byte_r             = a & v;
        rsp_o.subtract_out = 1'b0;
        rsp_o.half_out     = 1'b1;
        rsp_o.carry_out    = 1'b0;
      end
      caf_pkg::KIND_XOR, caf_pkg::KIND_OR: begin
        byte_r             = (req_i.kind == caf_pkg::KIND_XOR) ? (a ^ v) : (a | v);
        rsp_o.subtract_out = 1'b0;
        rsp_o.half_out     = 1'b0;
        rsp_o.carry_out    = 1'b0;
      end
      caf_pkg::KIND_INC: begin
        byte_r             = inc8;
        rsp_o.subtract_out = 1'b0;
        rsp_o.half_out     = (v[3:0] == 4'hf);
      end
      caf_pkg::KIND_DEC: begin
        byte_r             = dec8;
        rsp_o.subtract_out = 1'b1;
        rsp_o.half_out     = (v[3:0] == 4'h0);
      end
      caf_pkg::KIND_DAA: begin
        byte_r          = daa8;
        rsp_o.half_out  = 1'b0;
        rsp_o.carry_out = daa_c;
      end
      caf_pkg::KIND_CPL: begin
        byte_r             = ~a;
        rsp_o.subtract_out = 1'b1;
        rsp_o.half_out     = 1'b1;
      end
      caf_pkg::KIND_SCF, caf_pkg::KIND_CCF: begin
        rsp_o.subtract_out = 1'b0;
        rsp_o.half_out     = 1'b0;
        rsp_o.carry_out    = (req_i.kind == caf_pkg::KIND_SCF) ? 1'b1 : ~req_i.carry_in;
      end
      caf_pkg::KIND_ADD16: begin
        rsp_o.subtract_out = 1'b0;
        rsp_o.half_out     = add_lo12[12];
        rsp_o.carry_out    = add17[16];
      end
      caf_pkg::KIND_ADDSP: begin
        rsp_o.zero_out     = 1'b0;
        rsp_o.subtract_out = 1'b0;
        rsp_o.half_out     = ofs_nib[4];
        rsp_o.carry_out    = ofs_byte[8];
      end
      default: begin
      end
    endcase

    // byte ops: zero-extend; Z from the byte result, but CP takes it from the difference and CPL/SCF/CCF keep it
    case (req_i.kind)
      caf_pkg::KIND_ADD16: rsp_o.result = add17[15:0];
      caf_pkg::KIND_ADDSP: rsp_o.result = ofs16;
      default: begin
        rsp_o.result = {8'd0, byte_r};
        case (req_i.kind) inside
          caf_pkg::KIND_CP:                   rsp_o.zero_out = (sub9[7:0] == 8'd0);
          caf_pkg::KIND_CPL, caf_pkg::KIND_SCF,
          caf_pkg::KIND_CCF:                  rsp_o.zero_out = req_i.zero_in;
          default:                            rsp_o.zero_out = (byte_r == 8'd0);
        endcase
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/cpu_alu_flags.sv -----
// Top level: two-register pipeline around the ALU and flag unit.
//
//  channel | dir | payload    | handshake
//  req_i   | in  | caf_req_t  | valid/ready, request taken when both high
//  rsp_o   | out | caf_rsp_t  | valid/ready, result request taken when both high
//
// A request passes the request register, then the result register; one request
// per cycle is accepted, one result request per cycle leaves, while rsp_o.ready stays high.
// The ALU is a single combinational pass between the two registers.
// Reset clears both stage valid bits; payload registers are not reset.
// A stalled result request holds; req_i.ready drops only when both stages are full.
`default_nettype none
module cpu_alu_flags (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  caf_stream_if.sink   req_i,
  caf_stream_if.source rsp_o
);

  caf_pkg::caf_req_t s1_q;
  logic              v1_q;
  caf_pkg::caf_rsp_t rsp_d;
  caf_pkg::caf_rsp_t rsp_q;
  logic              v2_q;
  logic              adv1;
  logic              adv2;

  assign adv2        = !v2_q || rsp_o.ready;
  assign adv1        = !v1_q || adv2;
  assign req_i.ready = adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= req_i.valid;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && req_i.valid) s1_q <= req_i.data;
    if (adv2 && v1_q)        rsp_q <= rsp_d;
  end

  caf_alu u_alu (
    .req_i (s1_q),
    .rsp_o (rsp_d)
  );

  assign rsp_o.valid = v2_q;
  assign rsp_o.data  = rsp_q;

`ifndef SYNTHESIS
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> v1_q)
    else $error("accepted request did not reach stage 1");

  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request accepted while pipeline full and stalled");

  a_s1_moves_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && adv2) |=> rsp_o.valid)
    else $error("stage 1 request did not produce a response");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for cpu_alu_flags: random and directed ALU requests checked against a local model.
module tb_top;
  import caf_pkg::*;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  caf_stream_if #(.data_t(caf_req_t)) req_if ();
  caf_stream_if #(.data_t(caf_rsp_t)) rsp_if ();

  cpu_alu_flags i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  caf_req_t ops_to_issue[$];
  caf_rsp_t alu_results_due[$];
  int       ops_issued   = 0;
  int       mismatch_cnt = 0;
  logic     steady;

  // no random idling on either side for a stretch in the middle of the run
  assign steady = (ops_issued >= 700) && (ops_issued < 1100);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic caf_rsp_t predict_alu_flags(caf_req_t q);
    caf_rsp_t    res;
    logic        cin;
    logic [7:0]  val;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [12:0] sum13;
    logic [16:0] sum17;
    res.result       = {8'h00, q.acc};
    res.zero_out     = q.zero_in;
    res.subtract_out = q.subtract_in;
    res.half_out     = q.half_in;
    res.carry_out    = q.carry_in;
    case (q.kind)
      KIND_ADD, KIND_ADC: begin
        cin  = (q.kind == KIND_ADC) && q.carry_in;
        sum9 = {1'b0, q.acc} + {1'b0, q.operand} + {8'h00, cin};
        nib5 = {1'b0, q.acc[3:0]} + {1'b0, q.operand[3:0]} + {4'h0, cin};
        res.result       = {8'h00, sum9[7:0]};
        res.zero_out     = (sum9[7:0] == 8'h00);
        res.subtract_out = 1'b0;
        res.half_out     = nib5[4];
        res.carry_out    = sum9[8];
      end
      KIND_SUB, KIND_SBC, KIND_CP: begin
        cin  = (q.kind == KIND_SBC) && q.carry_in;
        // bit above the top is the borrow
        sum9 = {1'b0, q.acc} - {1'b0, q.operand} - {8'h00, cin};
        nib5 = {1'b0, q.acc[3:0]} - {1'b0, q.operand[3:0]} - {4'h0, cin};
        res.result       = (q.kind == KIND_CP) ? {8'h00, q.acc} : {8'h00, sum9[7:0]};
        res.zero_out     = (sum9[7:0] == 8'h00);
        res.subtract_out = 1'b1;
        res.half_out     = nib5[4];
        res.carry_out    = sum9[8];
      end
      KIND_AND, KIND_XOR, KIND_OR: begin
        val = (q.kind == KIND_AND) ? (q.acc & q.operand) :
              (q.kind == KIND_XOR) ? (q.acc ^ q.operand) : (q.acc | q.operand);
        res.result       = {8'h00, val};
        res.zero_out     = (val == 8'h00);
        res.subtract_out = 1'b0;
        res.half_out     = (q.kind == KIND_AND);
        res.carry_out    = 1'b0;
      end
      KIND_INC: begin
        val = q.operand + 8'h01;
        res.result       = {8'h00, val};
        res.zero_out     = (val == 8'h00);
        res.subtract_out = 1'b0;
        res.half_out     = (q.operand[3:0] == 4'hf);
      end
      KIND_DEC: begin
        val = q.operand - 8'h01;
        res.result       = {8'h00, val};
        res.zero_out     = (val == 8'h00);
        res.subtract_out = 1'b1;
        res.half_out     = (q.operand[3:0] == 4'h0);
      end
      KIND_DAA: begin
        val = q.acc;
        if (q.subtract_in) begin
          if (q.carry_in) val = val - 8'h60;
          if (q.half_in) val = val - 8'h06;
        end else begin
          if (q.carry_in || (q.acc > 8'h99)) begin
            val = val + 8'h60;
            res.carry_out = 1'b1;
          end
          if (q.half_in || (q.acc[3:0] > 4'h9)) val = val + 8'h06;
        end
        res.result   = {8'h00, val};
        res.zero_out = (val == 8'h00);
        res.half_out = 1'b0;
      end
      KIND_CPL: begin
        res.result       = {8'h00, ~q.acc};
        res.subtract_out = 1'b1;
        res.half_out     = 1'b1;
      end
      KIND_SCF, KIND_CCF: begin
        res.subtract_out = 1'b0;
        res.half_out     = 1'b0;
        res.carry_out    = (q.kind == KIND_SCF) ? 1'b1 : !q.carry_in;
      end
      KIND_ADD16: begin
        sum17 = {1'b0, q.wide_base} + {1'b0, q.wide_addend};
        sum13 = {1'b0, q.wide_base[11:0]} + {1'b0, q.wide_addend[11:0]};
        res.result       = sum17[15:0];
        res.subtract_out = 1'b0;
        res.half_out     = sum13[12];
        res.carry_out    = sum17[16];
      end
      KIND_ADDSP: begin
        // flags come from the unsigned low-byte add, the value from the signed one
        sum9 = {1'b0, q.wide_base[7:0]} + {1'b0, q.operand};
        nib5 = {1'b0, q.wide_base[3:0]} + {1'b0, q.operand[3:0]};
        res.result       = q.wide_base + {{8{q.operand[7]}}, q.operand};
        res.zero_out     = 1'b0;
        res.subtract_out = 1'b0;
        res.half_out     = nib5[4];
        res.carry_out    = sum9[8];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic caf_req_t make_req(caf_kind_e k, logic [7:0] a, logic [7:0] v,
                                        logic [15:0] base, logic [15:0] addend,
                                        logic [3:0] znhc);
    caf_req_t q;
    q.kind        = k;
    q.acc         = a;
    q.operand     = v;
    q.wide_base   = base;
    q.wide_addend = addend;
    q.zero_in     = znhc[3];
    q.subtract_in = znhc[2];
    q.half_in     = znhc[1];
    q.carry_in    = znhc[0];
    return q;
  endfunction

  // request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        alu_results_due.push_back(predict_alu_flags(req_if.data));
        ops_issued++;
      end
      if (!req_if.valid || req_if.ready) begin
        if ((ops_to_issue.size() > 0) && (steady || ($urandom_range(99) >= 19))) begin
          req_if.valid <= 1'b1;
          req_if.data  <= ops_to_issue.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (alu_results_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected response: result=%h z=%b n=%b h=%b c=%b",
                     rsp_if.data.result, rsp_if.data.zero_out, rsp_if.data.subtract_out,
                     rsp_if.data.half_out, rsp_if.data.carry_out);
        end else begin
          caf_rsp_t want;
          want = alu_results_due.pop_front();
          if ((rsp_if.data.result !== want.result) ||
              (rsp_if.data.zero_out !== want.zero_out) ||
              (rsp_if.data.subtract_out !== want.subtract_out) ||
              (rsp_if.data.half_out !== want.half_out) ||
              (rsp_if.data.carry_out !== want.carry_out)) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: exp result=%h znhc=%b%b%b%b, got result=%h znhc=%b%b%b%b",
                       want.result, want.zero_out, want.subtract_out, want.half_out,
                       want.carry_out, rsp_if.data.result, rsp_if.data.zero_out,
                       rsp_if.data.subtract_out, rsp_if.data.half_out,
                       rsp_if.data.carry_out);
          end
        end
      end
      rsp_if.ready <= steady || ($urandom_range(99) >= 19);
    end
  end

  initial begin
    caf_req_t q;
    // directed: extremes, zero results, carries at each boundary, DAA both ways
    ops_to_issue.push_back(make_req(KIND_ADD,   8'hff, 8'h01, 16'h0000, 16'h0000, 4'b0000));
    ops_to_issue.push_back(make_req(KIND_ADD,   8'h00, 8'h00, 16'hffff, 16'hffff, 4'b1111));
    ops_to_issue.push_back(make_req(KIND_ADC,   8'h0f, 8'h00, 16'h0000, 16'h0000, 4'b0001));
    ops_to_issue.push_back(make_req(KIND_ADC,   8'hff, 8'hff, 16'h0000, 16'h0000, 4'b0001));
    ops_to_issue.push_back(make_req(KIND_SUB,   8'h3c, 8'h3c, 16'h0000, 16'h0000, 4'b0000));
    ops_to_issue.push_back(make_req(KIND_SUB,   8'h10, 8'h01, 16'h0000, 16'h0000, 4'b1010));
    ops_to_issue.push_back(make_req(KIND_SBC,   8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0001));
    ops_to_issue.push_back(make_req(KIND_SBC,   8'h00, 8'hff, 16'h0000, 16'h0000, 4'b0001));
    ops_to_issue.push_back(make_req(KIND_AND,   8'hf0, 8'h0f, 16'h0000, 16'h0000, 4'b0101));
    ops_to_issue.push_back(make_req(KIND_XOR,   8'ha5, 8'ha5, 16'h0000, 16'h0000, 4'b0111));
    ops_to_issue.push_back(make_req(KIND_OR,    8'h00, 8'h00, 16'h0000, 16'h0000, 4'b0111));
    ops_to_issue.push_back(make_req(KIND_CP,    8'h42, 8'h42, 16'h0000, 16'h0000, 4'b0000));
    ops_to_issue.push_back(make_req(KIND_CP,    8'h00, 8'hff, 16'h0000, 16'h0000, 4'b1000));
    ops_to_issue.push_back(make_req(KIND_INC,   8'h55, 8'hff, 16'h0000, 16'h0000, 4'b0101));
    ops_to_issue.push_back(make_req(KIND_DEC,   8'h55, 8'h01, 16'h0000, 16'h0000, 4'b0010));
    ops_to_issue.push_back(make_req(KIND_DEC,   8'h55, 8'h00, 16'h0000, 16'h0000, 4'b0000));
    ops_to_issue.push_back(make_req(KIND_DAA,   8'h9a, 8'h00, 16'h0000, 16'h0000, 4'b0000));
    ops_to_issue.push_back(make_req(KIND_DAA,   8'h66, 8'h00, 16'h0000, 16'h0000, 4'b0111));
    ops_to_issue.push_back(make_req(KIND_CPL,   8'h5a, 8'h00, 16'h0000, 16'h0000, 4'b1001));
    ops_to_issue.push_back(make_req(KIND_SCF,   8'hc3, 8'h00, 16'h0000, 16'h0000, 4'b1110));
    ops_to_issue.push_back(make_req(KIND_CCF,   8'h3c, 8'h00, 16'h0000, 16'h0000, 4'b0111));
    ops_to_issue.push_back(make_req(KIND_CCF,   8'h3c, 8'h00, 16'h0000, 16'h0000, 4'b1000));
    ops_to_issue.push_back(make_req(KIND_ADD16, 8'h00, 8'h00, 16'hffff, 16'h0001, 4'b1000));
    ops_to_issue.push_back(make_req(KIND_ADD16, 8'h00, 8'h00, 16'h0fff, 16'h0001, 4'b0111));
    ops_to_issue.push_back(make_req(KIND_ADDSP, 8'h00, 8'h01, 16'hffff, 16'h0000, 4'b1111));
    ops_to_issue.push_back(make_req(KIND_ADDSP, 8'h00, 8'h80, 16'h0000, 16'hffff, 4'b1111));

    repeat (2000) begin
      q = make_req(caf_kind_e'($urandom_range(15)), 8'($urandom), 8'($urandom),
                   16'($urandom), 16'($urandom), 4'($urandom));
      // equal operands now and then, so zero and no-borrow cases come up often
      if ($urandom_range(7) == 0) q.operand = q.acc;
      ops_to_issue.push_back(q);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while ((ops_to_issue.size() > 0) || req_if.valid) @(posedge clk);
    while (alu_results_due.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if ((mismatch_cnt == 0) && (alu_results_due.size() == 0)) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
